FILE: rtl/core/eds_pkg.sv
package eds_pkg;

   localparam int MAX_DIM_DEFAULT       = 128;
   localparam int ELEMENT_WIDTH_DEFAULT = 16;

   localparam int SUM_W       = 40;
   localparam int DIST_W      = 20;
   localparam int COUNT_OUT_W = 8;

   // one result bit per step, trial bit walks from 2^40 down to 2^0
   localparam int ROOT_W     = SUM_W + 1;
   localparam int SQRT_STEPS = SUM_W / 2 + 1;
   localparam int STEP_CNT_W = $clog2(SQRT_STEPS);

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_LOAD,
      ST_ROOT,
      ST_DONE
   } eds_state_type;

   typedef struct packed {
      logic take;       // element transaction accepted this cycle
      logic last;       // accepted element closes the vector
      logic load;       // move the finished sum into the root unit
      logic step;       // one square root iteration
      logic out_load;   // capture the result into the output register
   } eds_cmd_type;

   typedef struct packed {
      logic out_free;   // output register empty or being emptied
   } eds_status_type;

endpackage

FILE: rtl/core/eds_req_if.sv
interface eds_req_if #(
   parameter int ELEM_W = 16
);
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] elem_a;
   logic [ELEM_W-1:0] elem_b;
   logic              last_element;

   modport source (output valid, output elem_a, output elem_b, output last_element,
                   input ready);
   modport sink   (input valid, input elem_a, input elem_b, input last_element,
                   output ready);
endinterface

FILE: rtl/core/eds_rsp_if.sv
interface eds_rsp_if;
   import eds_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [DIST_W-1:0]      distance;
   logic [COUNT_OUT_W-1:0] element_count;
   logic                   too_long;

   modport source (output valid, output distance, output element_count, output too_long,
                   input ready);
   modport sink   (input valid, input distance, input element_count, input too_long,
                   output ready);
endinterface

FILE: rtl/core/eds_ctrl.sv
module eds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  eds_pkg::eds_status_type status,
   output eds_pkg::eds_cmd_type    cmd
);
   import eds_pkg::*;

   eds_state_type           state_ff, state_in;
   logic [STEP_CNT_W-1:0]   step_cnt_ff, step_cnt_in;
   logic                    root_end;

   assign root_end = (step_cnt_ff == STEP_CNT_W'(SQRT_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_ACCUM;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM:  if (req_valid && req_last) state_in = ST_DRAIN1;
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_ROOT;
         ST_ROOT:   if (root_end) state_in = ST_DONE;
         ST_DONE:   if (status.out_free) state_in = ST_ACCUM;
         default:   state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      step_cnt_in = '0;
      case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            cmd.last  = req_valid && req_last;
         end
         ST_DRAIN1, ST_DRAIN2: ;
         ST_LOAD:  cmd.load = 1'b1;
         ST_ROOT: begin
            cmd.step    = 1'b1;
            step_cnt_in = root_end ? '0 : step_cnt_ff + 1'b1;
         end
         ST_DONE:  cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule

FILE: rtl/core/eds_dpath.sv
module eds_dpath #(
   parameter int MAX_DIM       = eds_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_WIDTH = eds_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  eds_pkg::eds_cmd_type              cmd,
   output eds_pkg::eds_status_type           status,
   input  logic [ELEMENT_WIDTH-1:0]          elem_a,
   input  logic [ELEMENT_WIDTH-1:0]          elem_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [eds_pkg::DIST_W-1:0]        distance,
   output logic [eds_pkg::COUNT_OUT_W-1:0]   element_count,
   output logic                              too_long
);
   import eds_pkg::*;

   localparam int MAG_W     = ELEMENT_WIDTH + 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int ACC_W     = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
   localparam int CNT_W     = $clog2(MAX_DIM + 1);
   localparam int CNT_EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

   // element count and overflow flag
   logic [CNT_W-1:0] count_ff, count_in, count_next;
   logic             ovf_ff, ovf_in, ovf_next;
   logic             fits;
   logic [CNT_W-1:0] res_count_ff, res_count_in;
   logic             res_ovf_ff, res_ovf_in;

   // accumulate pipeline: magnitude, square, sum
   logic [MAG_W-1:0] diff;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             a_vld_ff, a_vld_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             b_vld_ff;
   logic [ACC_W-1:0] sum_wide;
   logic [SUM_W-1:0] sum_ff, sum_in;

   // square root unit
   logic [SUM_W-1:0]  x_ff, x_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W-1:0] bit_ff, bit_in;
   logic [ROOT_W-1:0] trial;

   // output register
   logic                   out_vld_ff, out_vld_in;
   logic [DIST_W-1:0]      dist_ff;
   logic [CNT_EXT_W-1:0]   cnt_ext;
   logic [COUNT_OUT_W-1:0] cnt_out_ff;
   logic                   long_ff;

   assign fits       = (count_ff < CNT_W'(MAX_DIM));
   assign count_next = fits ? count_ff + 1'b1 : count_ff;
   assign ovf_next   = ovf_ff | ~fits;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      res_count_in = res_count_ff;
      res_ovf_in   = res_ovf_ff;
      if (cmd.take) begin
         if (cmd.last) begin
            res_count_in = count_next;
            res_ovf_in   = ovf_next;
            count_in     = '0;
            ovf_in       = 1'b0;
         end else begin
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end
   end

   assign diff     = {elem_a[ELEMENT_WIDTH-1], elem_a} - {elem_b[ELEMENT_WIDTH-1], elem_b};
   assign mag_in   = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
   assign a_vld_in = cmd.take && fits;
   assign sq_in    = SQ_W'(mag_ff) * SQ_W'(mag_ff);
   assign sum_wide = ACC_W'(sum_ff) + ACC_W'(sq_ff);

   always_comb begin
      sum_in = sum_ff;
      if (cmd.load) begin
         sum_in = '0;
      end else if (b_vld_ff) begin
         sum_in = (sum_wide > ACC_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
   end

   // restoring square root, one result bit per step
   assign trial = root_ff + bit_ff;

   always_comb begin
      x_in    = x_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.load) begin
         x_in    = sum_ff;
         root_in = '0;
         bit_in  = ROOT_W'(1) << SUM_W;
      end else if (cmd.step) begin
         bit_in = bit_ff >> 2;
         if (ROOT_W'(x_ff) >= trial) begin
            x_in    = x_ff - trial[SUM_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
      end
   end

   assign status.out_free = !out_vld_ff || rsp_ready;
   assign cnt_ext         = CNT_EXT_W'(res_count_ff);

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         sum_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= a_vld_ff;
         sum_ff     <= sum_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      res_count_ff <= res_count_in;
      res_ovf_ff   <= res_ovf_in;
      x_ff         <= x_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      if (cmd.out_load) begin
         dist_ff    <= root_ff[DIST_W-1:0];
         cnt_out_ff <= cnt_ext[COUNT_OUT_W-1:0];
         long_ff    <= res_ovf_ff;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign distance      = dist_ff;
   assign element_count = cnt_out_ff;
   assign too_long      = long_ff;

endmodule

FILE: rtl/core/euclidean_distance_stream.sv
// Element pairs are taken one per cycle while accumulating. After the last pair the input
// stalls while the sum drains and the 21-step restoring square root runs (one result bit
// per cycle), and until the output register is free to capture the result.
// A finished result waits in the output register while the next vector streams in.
// Reset (synchronous, active high) clears the sum, count, overflow flag and control state.
module euclidean_distance_stream #(
   parameter int MAX_DIM       = eds_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_WIDTH = eds_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   eds_req_if.sink req_chan,
   eds_rsp_if.source rsp_chan
);
   import eds_pkg::*;

   // controller <-> datapath
   eds_cmd_type    cmd;
   eds_status_type status;

   // Sequencer: ACCUM takes element transactions; on the last one DRAIN1 and DRAIN2
   // let the square and sum stages drain, then it loads the root unit, runs
   // the root iterations and then hands the result to the output register.
   eds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_element),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: |a-b| register, square register, saturating 40-bit sum,
   // count with overflow flag, iterative square root, output register.
   eds_dpath #(
      .MAX_DIM       (MAX_DIM),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .elem_a        (req_chan.elem_a),
      .elem_b        (req_chan.elem_b),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .distance      (rsp_chan.distance),
      .element_count (rsp_chan.element_count),
      .too_long      (rsp_chan.too_long)
   );

endmodule

FILE: sim/euclidean_distance_stream_checker.sv
`timescale 1ns / 100ps

module euclidean_distance_stream_checker (
   input  logic clock,
   input  logic reset,
   eds_req_if   req_mon,
   eds_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   vectors_checked,
   output int   overlong_vectors
);
   import eds_pkg::*;

   localparam int MAX_DIM = MAX_DIM_DEFAULT;
   localparam int EW      = ELEMENT_WIDTH_DEFAULT;

   typedef logic [EW-1:0] elem_type;

   typedef struct packed {
      logic [DIST_W-1:0]      distance;
      logic [COUNT_OUT_W-1:0] element_count;
      logic                   too_long;
   } distance_result_type;

   distance_result_type expected_distances[$];

   // running vector state
   logic [SUM_W-1:0] sum_sq      = '0;
   int unsigned      pairs_in    = 0;
   logic             past_limit  = 1'b0;

   function automatic logic [DIST_W:0] floor_root(input logic [SUM_W-1:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int k = DIST_W; k >= 0; k--) begin
         trial = root | (64'd1 << k);
         if (trial * trial <= 64'(x)) root = trial;
      end
      return root[DIST_W:0];
   endfunction

   // folds one pair into the vector state; returns 1 when the vector closes
   function automatic logic fold_pair(input elem_type a, input elem_type b,
                                      input logic last_flag,
                                      output distance_result_type res);
      longint      diff;
      logic [63:0] sq;
      res = '0;
      if (pairs_in < MAX_DIM) begin
         diff = longint'($signed(a)) - longint'($signed(b));
         if (diff < 0) diff = -diff;
         sq = 64'(diff) * 64'(diff);
         if (sq >= 64'(SUM_MAX) - 64'(sum_sq)) sum_sq = SUM_MAX;
         else sum_sq = sum_sq + SUM_W'(sq);
         pairs_in++;
      end else begin
         past_limit = 1'b1;
      end
      if (!last_flag) return 1'b0;
      res.distance      = DIST_W'(floor_root(sum_sq));
      res.element_count = COUNT_OUT_W'(pairs_in);
      res.too_long      = past_limit;
      sum_sq     = '0;
      pairs_in   = 0;
      past_limit = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      distance_result_type got;
      distance_result_type want;
      if (reset) begin
         sum_sq     = '0;
         pairs_in   = 0;
         past_limit = 1'b0;
         expected_distances.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.distance      = rsp_mon.distance;
            got.element_count = rsp_mon.element_count;
            got.too_long      = rsp_mon.too_long;
            if (expected_distances.size() == 0) begin
               $error("unexpected result transaction: distance %0d, count %0d, too_long %0b",
                      got.distance, got.element_count, got.too_long);
               mismatches++;
            end else begin
               want = expected_distances.pop_front();
               if (got.distance !== want.distance) begin
                  $error("distance: expected %0d, actual %0d", want.distance, got.distance);
                  mismatches++;
               end
               if (got.element_count !== want.element_count) begin
                  $error("element_count: expected %0d, actual %0d",
                         want.element_count, got.element_count);
                  mismatches++;
               end
               if (got.too_long !== want.too_long) begin
                  $error("too_long: expected %0b, actual %0b", want.too_long, got.too_long);
                  mismatches++;
               end
               vectors_checked++;
               if (want.too_long) overlong_vectors++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (fold_pair(req_mon.elem_a, req_mon.elem_b, req_mon.last_element, want))
               expected_distances = {expected_distances, want};
         end
      end
      outstanding = expected_distances.size();
   end

endmodule

FILE: sim/euclidean_distance_stream_test.sv
`timescale 1ns / 100ps

module euclidean_distance_stream_test;
   import eds_pkg::*;

   localparam int EW           = ELEMENT_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;  // watchdog limit for the whole run
   localparam int HOLD_CYCLES  = 300;     // long receiver back-pressure window
   localparam int PHASE_ITEMS  = 140;     // element pairs per idling phase
   localparam int TAIL_ITEMS   = 100;     // random pairs in the no-idle phase
   localparam int DRAIN_CYCLES = 40;      // idle wait at the end, after all results are in

   typedef logic [EW-1:0] elem_type;

   localparam elem_type ELEM_MAX  = {1'b0, {(EW-1){1'b1}}};
   localparam elem_type ELEM_MIN  = {1'b1, {(EW-1){1'b0}}};
   localparam elem_type ELEM_ZERO = '0;
   localparam elem_type ELEM_ONE  = elem_type'(1);
   localparam elem_type ELEM_NEG1 = '1;

   logic clock;
   logic reset;

   int cycle_count    = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_epoch     = 0;  // bumped by stimulus to request a hold-off
   int hold_seen      = 0;
   int hold_left      = 0;

   int mismatches;
   int outstanding;
   int vectors_checked;
   int overlong_vectors;

   eds_req_if #(.ELEM_W(EW)) req_chan ();
   eds_rsp_if                rsp_chan ();

   euclidean_distance_stream #(
      .MAX_DIM       (MAX_DIM_DEFAULT),
      .ELEMENT_WIDTH (EW)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicts every distance from the accepted pairs and compares result transactions
   euclidean_distance_stream_checker l2_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .vectors_checked  (vectors_checked),
      .overlong_vectors (overlong_vectors)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results pending", cycle_count, outstanding);
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold-off on request.
   // The hold is counted here so the sender keeps streaming meanwhile.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_epoch != hold_seen) begin
         hold_seen      <= hold_epoch;
         hold_left      <= HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Offers one element pair; entered and left at a falling edge.
   // Random gaps are inserted ahead of the transaction.
   task automatic offer_pair(input elem_type a, input elem_type b, input logic last_flag);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.elem_a       <= a;
      req_chan.elem_b       <= b;
      req_chan.last_element <= last_flag;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly uniform, with a share of the corner values
   function automatic elem_type pick_element();
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 3))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return ELEM_ZERO;
            default: return ELEM_NEG1;
         endcase
      end
      return elem_type'($urandom());
   endfunction

   // one complete vector pair of random content, last flag on the final element
   task automatic send_vector(input int len);
      elem_type a;
      elem_type b;
      for (int i = 0; i < len; i++) begin
         a = pick_element();
         // near-equal elements give small distances
         if ($urandom_range(0, 99) < 15)
            b = a + elem_type'($urandom_range(0, 8)) - elem_type'(4);
         else b = pick_element();
         offer_pair(a, b, i == len - 1);
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 8);
      if (r < 95) return $urandom_range(9, 40);
      return $urandom_range(100, MAX_DIM_DEFAULT);
   endfunction

   // drop valid, then sit until the checker holds no expectation
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic run_random(input int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) send_vector(pick_length());
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.elem_a       = '0;
      req_chan.elem_b       = '0;
      req_chan.last_element = 1'b0;
      rsp_chan.ready        = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 23;
      recv_idle_pct <= 49;
      @(negedge clock);

      // directed: one-pair vectors at the field extremes
      offer_pair(ELEM_MAX, ELEM_MIN, 1'b1);    // largest positive difference
      offer_pair(ELEM_MIN, ELEM_MAX, 1'b1);    // largest negative difference
      offer_pair(ELEM_ZERO, ELEM_ZERO, 1'b1);  // zero distance
      offer_pair(ELEM_MIN, ELEM_MIN, 1'b1);
      offer_pair(ELEM_MAX, ELEM_MAX, 1'b1);
      offer_pair(ELEM_ONE, ELEM_ZERO, 1'b1);   // smallest nonzero step
      offer_pair(ELEM_NEG1, ELEM_ZERO, 1'b1);
      offer_pair(ELEM_ZERO, ELEM_MIN, 1'b1);
      // 3-4-5: exact root over two pairs
      offer_pair(elem_type'(3), ELEM_ZERO, 1'b0);
      offer_pair(ELEM_ZERO, elem_type'(4), 1'b1);
      // sum of 2 floors to 1
      offer_pair(ELEM_ONE, ELEM_ZERO, 1'b0);
      offer_pair(ELEM_ZERO, ELEM_ONE, 1'b1);
      // four maximal differences, largest short-vector sum
      for (int i = 0; i < 4; i++) offer_pair(ELEM_MAX, ELEM_MIN, i == 3);
      wait_for_results();

      // phase 1: sender idles lightly, receiver heavily; one vector at the dimension limit
      send_vector(MAX_DIM_DEFAULT);
      run_random(PHASE_ITEMS - MAX_DIM_DEFAULT);
      wait_for_results();

      // phase 2: roles swapped; one vector past the limit, count saturates and flag sets
      send_idle_pct <= 49;
      recv_idle_pct <= 23;
      send_vector(MAX_DIM_DEFAULT + $urandom_range(1, 12));
      run_random(PHASE_ITEMS - MAX_DIM_DEFAULT);
      wait_for_results();

      // phase 3: no idling; first a long receiver hold-off while short vectors keep coming
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_epoch    <= hold_epoch + 1;
      for (int i = 0; i < 8; i++) send_vector($urandom_range(1, 3));
      wait_for_results();
      run_random(TAIL_ITEMS);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d element pairs in %0d vectors, %0d of them past the dimension limit",
               items_sent, vectors_checked, overlong_vectors);
      $display("%0d mismatches, %0d results still pending", mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
